// ===== sv/mtpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpm_pkg: shared types and constants
// Sizes, memory word layouts, item classes and sequencer states for the
// three-level 8-8-8 multibit trie prefix match core.
// ----------------------------------------------------------------------------
package mtpm_pkg;

  // Sizing constants.
  localparam int ID_BITS     = 16;
  localparam int L2_NODES    = 256;
  localparam int L3_NODES    = 1024;
  localparam int STRIDE      = 8;
  localparam int FANOUT      = 256;
  localparam int ADDR_W      = 24;
  localparam int LEN_W       = 5;
  localparam int OUT_ID_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int MAX_LEN     = 24;

  localparam int L2_IDX_W    = (L2_NODES > 1) ? $clog2(L2_NODES) : 1;
  localparam int L3_IDX_W    = (L3_NODES > 1) ? $clog2(L3_NODES) : 1;
  localparam int L2_CNT_W    = $clog2(L2_NODES + 1);
  localparam int L3_CNT_W    = $clog2(L3_NODES + 1);
  localparam int L2_DEPTH    = L2_NODES * FANOUT;
  localparam int L3_DEPTH    = L3_NODES * FANOUT;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_L2_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_L3_FULL = 2'd2;

  typedef logic [STRIDE-1:0]   idx_t;
  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [L2_IDX_W-1:0] l2_node_t;
  typedef logic [L3_IDX_W-1:0] l3_node_t;

  // Item classes decided by the front end.
  typedef enum logic [2:0] {
    K_LOOKUP,
    K_NOP,
    K_L1,
    K_L2,
    K_L3
  } kind_t;

  // Classified item carried through the queue.
  typedef struct packed {
    kind_t                kind;
    logic [ADDR_W-1:0]    address;
    len_t                 len;
    id_t                  id;
    idx_t                 mask;
  } item_t;

  // Memory word layouts.
  typedef struct packed {
    logic     valid;
    id_t      id;
    len_t     len;
    logic     has_child;
    l2_node_t child;
  } l1_word_t;

  typedef struct packed {
    logic     valid;
    id_t      id;
    len_t     len;
    logic     has_child;
    l3_node_t child;
  } l2_word_t;

  typedef struct packed {
    logic valid;
    id_t  id;
    len_t len;
  } l3_word_t;

  // Sequencer states of the back end.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LK2,
    S_LK3,
    S_LK4,
    S_IN2,
    S_IN3,
    S_CLR2,
    S_ALLOC3,
    S_CLR3,
    S_EXP_RD,
    S_EXP_WR,
    S_DONE,
    S_INIT
  } state_t;

endpackage

// ===== sv/mtpm_front.sv =====
// ----------------------------------------------------------------------------
// mtpm_front: input stage and item queue
// Accepts input transfers, classifies each item by operation and trie level,
// computes its expansion mask and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module mtpm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [mtpm_pkg::ADDR_W-1:0]   address,
  input  logic [mtpm_pkg::LEN_W-1:0]    prefix_length,
  input  logic [15:0]                   prefix_id,
  output logic                          q_valid,
  input  logic                          q_ready,
  output mtpm_pkg::item_t               q_item
);

  mtpm_pkg::item_t fifo [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  mtpm_pkg::item_t item_new;
  logic [3:0]      span_bits;
  logic            push;
  logic            pop;

  // Classify the incoming item and derive the span of entries it covers.
  always_comb begin
    span_bits     = 4'd0;
    item_new.kind = mtpm_pkg::K_LOOKUP;
    if (!mode) begin
      if (prefix_length > mtpm_pkg::LEN_W'(mtpm_pkg::MAX_LEN)) begin
        item_new.kind = mtpm_pkg::K_NOP;
      end else if (prefix_length <= mtpm_pkg::LEN_W'(8)) begin
        item_new.kind = mtpm_pkg::K_L1;
        span_bits     = 4'(mtpm_pkg::LEN_W'(8) - prefix_length);
      end else if (prefix_length <= mtpm_pkg::LEN_W'(16)) begin
        item_new.kind = mtpm_pkg::K_L2;
        span_bits     = 4'(mtpm_pkg::LEN_W'(16) - prefix_length);
      end else begin
        item_new.kind = mtpm_pkg::K_L3;
        span_bits     = 4'(mtpm_pkg::LEN_W'(24) - prefix_length);
      end
    end
    item_new.address = address;
    item_new.len     = prefix_length;
    item_new.id      = mtpm_pkg::ID_BITS'(prefix_id);
    item_new.mask    = 8'((9'd1 << span_bits) - 9'd1);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item_new;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/mtpm_engine.sv =====
// ----------------------------------------------------------------------------
// mtpm_engine: trie sequencer, tables and result register
// Takes classified items from the queue, walks the trie for lookups, and
// for inserts allocates and clears nodes and expands prefixes entry by entry.
// ----------------------------------------------------------------------------
module mtpm_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  mtpm_pkg::item_t                 q_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mtpm_pkg::OUT_ID_W-1:0]   best_id,
  output logic [mtpm_pkg::LEN_W-1:0]      best_length,
  output logic [mtpm_pkg::STATUS_W-1:0]   status
);

  localparam int L2_AW = mtpm_pkg::L2_IDX_W + mtpm_pkg::STRIDE;
  localparam int L3_AW = mtpm_pkg::L3_IDX_W + mtpm_pkg::STRIDE;

  // Memories.
  mtpm_pkg::l1_word_t l1_mem [mtpm_pkg::FANOUT];
  mtpm_pkg::l2_word_t l2_mem [mtpm_pkg::L2_DEPTH];
  mtpm_pkg::l3_word_t l3_mem [mtpm_pkg::L3_DEPTH];

  mtpm_pkg::l1_word_t l1_rdata, l1_wdata;
  mtpm_pkg::l2_word_t l2_rdata, l2_wdata;
  mtpm_pkg::l3_word_t l3_rdata, l3_wdata;
  mtpm_pkg::idx_t     l1_raddr, l1_waddr;
  logic [L2_AW-1:0]   l2_raddr, l2_waddr;
  logic [L3_AW-1:0]   l3_raddr, l3_waddr;
  logic               l1_we, l2_we, l3_we;

  // Sequencer state and working registers.
  mtpm_pkg::state_t   state, state_next;
  mtpm_pkg::item_t    cur;
  mtpm_pkg::idx_t     i;
  mtpm_pkg::l2_node_t c2;
  mtpm_pkg::l3_node_t c3;
  mtpm_pkg::l2_word_t word2;
  logic [mtpm_pkg::L2_CNT_W-1:0] nf2;
  logic [mtpm_pkg::L3_CNT_W-1:0] nf3;
  mtpm_pkg::id_t      acc_id;
  mtpm_pkg::len_t     acc_len;
  logic [mtpm_pkg::STATUS_W-1:0] acc_status;

  mtpm_pkg::idx_t a1, a2, a3, stride_sel, from_cur, to_cur;
  logic           need2, need3, l2_full, l3_full, deep, upd_cond, slot_free;

  assign a1 = cur.address[23:16];
  assign a2 = cur.address[15:8];
  assign a3 = cur.address[7:0];
  assign deep    = (cur.kind == mtpm_pkg::K_L3);
  assign l2_full = (nf2 >= mtpm_pkg::L2_CNT_W'(mtpm_pkg::L2_NODES));
  assign l3_full = (nf3 >= mtpm_pkg::L3_CNT_W'(mtpm_pkg::L3_NODES));
  assign need2   = !l1_rdata.has_child;
  assign need3   = !l2_rdata.has_child;
  assign slot_free = !out_valid || out_ready;
  assign q_ready = (state == mtpm_pkg::S_IDLE);

  // Expansion range within the node of the item's level.
  always_comb begin
    case (cur.kind)
      mtpm_pkg::K_L1: stride_sel = a1;
      mtpm_pkg::K_L2: stride_sel = a2;
      default:        stride_sel = a3;
    endcase
    from_cur = stride_sel & ~cur.mask;
    to_cur   = from_cur | cur.mask;
  end

  // Replacement test on the entry read for expansion.
  always_comb begin
    case (cur.kind)
      mtpm_pkg::K_L1: upd_cond = !l1_rdata.valid || (cur.len > l1_rdata.len);
      mtpm_pkg::K_L2: upd_cond = !l2_rdata.valid || (cur.len > l2_rdata.len);
      default:        upd_cond = !l3_rdata.valid || (cur.len > l3_rdata.len);
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mtpm_pkg::S_INIT: begin
        if (i == '1) state_next = mtpm_pkg::S_IDLE;
      end
      mtpm_pkg::S_IDLE: begin
        if (q_valid) state_next = mtpm_pkg::S_START;
      end
      mtpm_pkg::S_START: begin
        case (cur.kind)
          mtpm_pkg::K_LOOKUP: state_next = mtpm_pkg::S_LK2;
          mtpm_pkg::K_L1:     state_next = mtpm_pkg::S_EXP_RD;
          mtpm_pkg::K_L2:     state_next = mtpm_pkg::S_IN2;
          mtpm_pkg::K_L3:     state_next = mtpm_pkg::S_IN2;
          default:            state_next = mtpm_pkg::S_DONE;
        endcase
      end
      mtpm_pkg::S_LK2: begin
        state_next = l1_rdata.has_child ? mtpm_pkg::S_LK3 : mtpm_pkg::S_DONE;
      end
      mtpm_pkg::S_LK3: begin
        state_next = l2_rdata.has_child ? mtpm_pkg::S_LK4 : mtpm_pkg::S_DONE;
      end
      mtpm_pkg::S_LK4: state_next = mtpm_pkg::S_DONE;
      mtpm_pkg::S_IN2: begin
        if (need2) begin
          if (l2_full || (deep && l3_full)) state_next = mtpm_pkg::S_DONE;
          else                              state_next = mtpm_pkg::S_CLR2;
        end else begin
          state_next = deep ? mtpm_pkg::S_IN3 : mtpm_pkg::S_EXP_RD;
        end
      end
      mtpm_pkg::S_IN3: begin
        if (need3) state_next = l3_full ? mtpm_pkg::S_DONE : mtpm_pkg::S_ALLOC3;
        else       state_next = mtpm_pkg::S_EXP_RD;
      end
      mtpm_pkg::S_CLR2: begin
        if (i == '1) state_next = deep ? mtpm_pkg::S_ALLOC3 : mtpm_pkg::S_EXP_RD;
      end
      mtpm_pkg::S_ALLOC3: state_next = mtpm_pkg::S_CLR3;
      mtpm_pkg::S_CLR3: begin
        if (i == '1) state_next = mtpm_pkg::S_EXP_RD;
      end
      mtpm_pkg::S_EXP_RD: state_next = mtpm_pkg::S_EXP_WR;
      mtpm_pkg::S_EXP_WR: begin
        state_next = (i == to_cur) ? mtpm_pkg::S_DONE : mtpm_pkg::S_EXP_RD;
      end
      mtpm_pkg::S_DONE: begin
        if (slot_free) state_next = mtpm_pkg::S_IDLE;
      end
      default: state_next = mtpm_pkg::S_IDLE;
    endcase
  end

  // Memory addresses and write strobes.
  always_comb begin
    l1_raddr = a1;
    l2_raddr = {l1_rdata.child, a2};
    l3_raddr = {l2_rdata.child, a3};
    l1_we    = 1'b0;
    l2_we    = 1'b0;
    l3_we    = 1'b0;
    l1_waddr = a1;
    l2_waddr = {c2, i};
    l3_waddr = {c3, i};
    l1_wdata = l1_rdata;
    l2_wdata = '0;
    l3_wdata = '0;
    case (state)
      mtpm_pkg::S_INIT: begin
        l1_we    = 1'b1;
        l1_waddr = i;
        l1_wdata = '0;
      end
      mtpm_pkg::S_IN2: begin
        if (need2 && !l2_full && !(deep && l3_full)) begin
          l1_we              = 1'b1;
          l1_wdata.has_child = 1'b1;
          l1_wdata.child     = mtpm_pkg::L2_IDX_W'(nf2);
        end
      end
      mtpm_pkg::S_CLR2: l2_we = 1'b1;
      mtpm_pkg::S_ALLOC3: begin
        l2_we              = 1'b1;
        l2_waddr           = {c2, a2};
        l2_wdata           = word2;
        l2_wdata.has_child = 1'b1;
        l2_wdata.child     = mtpm_pkg::L3_IDX_W'(nf3);
      end
      mtpm_pkg::S_CLR3: l3_we = 1'b1;
      mtpm_pkg::S_EXP_RD: begin
        l1_raddr = i;
        l2_raddr = {c2, i};
        l3_raddr = {c3, i};
      end
      mtpm_pkg::S_EXP_WR: begin
        l1_waddr       = i;
        l1_wdata.valid = 1'b1;
        l1_wdata.id    = cur.id;
        l1_wdata.len   = cur.len;
        l2_wdata       = l2_rdata;
        l2_wdata.valid = 1'b1;
        l2_wdata.id    = cur.id;
        l2_wdata.len   = cur.len;
        l3_wdata.valid = 1'b1;
        l3_wdata.id    = cur.id;
        l3_wdata.len   = cur.len;
        if (upd_cond) begin
          case (cur.kind)
            mtpm_pkg::K_L1: l1_we = 1'b1;
            mtpm_pkg::K_L2: l2_we = 1'b1;
            default:        l3_we = 1'b1;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Level-one table.
  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
    l1_rdata <= l1_mem[l1_raddr];
  end

  // Level-two node store.
  always_ff @(posedge clk) begin
    if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
    l2_rdata <= l2_mem[l2_raddr];
  end

  // Level-three node store.
  always_ff @(posedge clk) begin
    if (l3_we) l3_mem[l3_waddr] <= l3_wdata;
    l3_rdata <= l3_mem[l3_raddr];
  end

  // Control state: sequencer, pool counters, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtpm_pkg::S_INIT;
      nf2       <= '0;
      nf3       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mtpm_pkg::S_IN2 && l1_we) begin
        nf2 <= nf2 + 1'b1;
      end
      if (state == mtpm_pkg::S_ALLOC3) begin
        nf3 <= nf3 + 1'b1;
      end
      if (state == mtpm_pkg::S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
    end else begin
      case (state)
        mtpm_pkg::S_INIT: i <= i + 1'b1;
        mtpm_pkg::S_IDLE: begin
          cur        <= q_item;
          acc_id     <= '0;
          acc_len    <= '0;
          acc_status <= mtpm_pkg::STATUS_OK;
        end
        mtpm_pkg::S_START: i <= from_cur;
        mtpm_pkg::S_LK2: begin
          if (l1_rdata.valid) begin
            acc_id  <= l1_rdata.id;
            acc_len <= l1_rdata.len;
          end
        end
        mtpm_pkg::S_LK3: begin
          if (l2_rdata.valid) begin
            acc_id  <= l2_rdata.id;
            acc_len <= l2_rdata.len;
          end
        end
        mtpm_pkg::S_LK4: begin
          if (l3_rdata.valid) begin
            acc_id  <= l3_rdata.id;
            acc_len <= l3_rdata.len;
          end
        end
        mtpm_pkg::S_IN2: begin
          i     <= from_cur;
          word2 <= '0;
          if (need2) begin
            c2 <= mtpm_pkg::L2_IDX_W'(nf2);
            i  <= '0;
            if (l2_full) acc_status <= mtpm_pkg::STATUS_L2_FULL;
            else if (deep && l3_full) acc_status <= mtpm_pkg::STATUS_L3_FULL;
          end else begin
            c2 <= l1_rdata.child;
          end
        end
        mtpm_pkg::S_IN3: begin
          word2 <= l2_rdata;
          c3    <= l2_rdata.child;
          i     <= from_cur;
          if (need3 && l3_full) acc_status <= mtpm_pkg::STATUS_L3_FULL;
        end
        mtpm_pkg::S_CLR2: i <= (i == '1) ? from_cur : i + 1'b1;
        mtpm_pkg::S_ALLOC3: begin
          c3 <= mtpm_pkg::L3_IDX_W'(nf3);
          i  <= '0;
        end
        mtpm_pkg::S_CLR3: i <= (i == '1) ? from_cur : i + 1'b1;
        mtpm_pkg::S_EXP_WR: i <= i + 1'b1;
        mtpm_pkg::S_DONE: begin
          if (slot_free) begin
            best_id     <= mtpm_pkg::OUT_ID_W'(acc_id);
            best_length <= acc_len;
            status      <= acc_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/multibit_trie_prefix_match_core.sv =====
// Lookup: the sequencer walks the trie level by level, stopping where a node
// has no child, and takes the next item only once the last result is registered.
// Insert: ignored lengths go straight to the result; others clear new nodes
// entry by entry on one write port, then read and write back each expanded entry.
// Reset starts a pass that clears the level-one table; the queue and both pool
// counters clear at once, and deeper nodes are cleared when allocated.
// ----------------------------------------------------------------------------
// multibit_trie_prefix_match_core: 8-8-8 multibit trie longest prefix match
// Front end queues and classifies items; back end walks and updates the trie.
// ----------------------------------------------------------------------------
module multibit_trie_prefix_match_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [mtpm_pkg::ADDR_W-1:0]   address,
  input  logic [mtpm_pkg::LEN_W-1:0]    prefix_length,
  input  logic [15:0]                   prefix_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtpm_pkg::OUT_ID_W-1:0] best_id,
  output logic [mtpm_pkg::LEN_W-1:0]    best_length,
  output logic [mtpm_pkg::STATUS_W-1:0] status
);

  logic            q_valid;
  logic            q_ready;
  mtpm_pkg::item_t q_item;

  // Input stage and item queue.
  mtpm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .address       (address),
    .prefix_length (prefix_length),
    .prefix_id     (prefix_id),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  // Trie sequencer and result register.
  mtpm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .best_id     (best_id),
    .best_length (best_length),
    .status      (status)
  );

endmodule

// ===== verif/multibit_trie_prefix_match_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_prefix_match_core_test: self-checking bench for the trie core
// A table of directed items is followed by random inserts and lookups under
// several idle and stall patterns. Each result is checked against a behavioral
// trie, or against the row's own expected result for typed directed rows.
// ----------------------------------------------------------------------------
module multibit_trie_prefix_match_core_test;

  typedef struct packed {
    mtpm_pkg::id_t                 id;
    mtpm_pkg::len_t                len;
    logic [mtpm_pkg::STATUS_W-1:0] status;
  } match_t;

  typedef struct {
    bit          mode;
    logic [23:0] address;
    logic [4:0]  len;
    logic [15:0] id;
    bit          typed;
    match_t      want;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          mode = 1'b0;
  logic [mtpm_pkg::ADDR_W-1:0]   address = '0;
  logic [mtpm_pkg::LEN_W-1:0]    prefix_length = '0;
  logic [15:0]                   prefix_id = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mtpm_pkg::OUT_ID_W-1:0] best_id;
  logic [mtpm_pkg::LEN_W-1:0]    best_length;
  logic [mtpm_pkg::STATUS_W-1:0] status;

  multibit_trie_prefix_match_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .address(address), .prefix_length(prefix_length),
    .prefix_id(prefix_id), .out_valid(out_valid), .out_ready(out_ready),
    .best_id(best_id), .best_length(best_length), .status(status)
  );

  always #1 clk = ~clk;

  // Behavioral copy of the trie.
  bit              t1_valid [mtpm_pkg::FANOUT];
  mtpm_pkg::id_t   t1_id    [mtpm_pkg::FANOUT];
  mtpm_pkg::len_t  t1_len   [mtpm_pkg::FANOUT];
  bit              t1_hc    [mtpm_pkg::FANOUT];
  int              t1_child [mtpm_pkg::FANOUT];
  bit              t2_valid [mtpm_pkg::L2_DEPTH];
  mtpm_pkg::id_t   t2_id    [mtpm_pkg::L2_DEPTH];
  mtpm_pkg::len_t  t2_len   [mtpm_pkg::L2_DEPTH];
  bit              t2_hc    [mtpm_pkg::L2_DEPTH];
  int              t2_child [mtpm_pkg::L2_DEPTH];
  bit              t3_valid [mtpm_pkg::L3_DEPTH];
  mtpm_pkg::id_t   t3_id    [mtpm_pkg::L3_DEPTH];
  mtpm_pkg::len_t  t3_len   [mtpm_pkg::L3_DEPTH];
  int              l2_taken;
  int              l3_taken;

  match_t          pending_matches[$];
  logic [23:0]     known_prefixes[$];
  int              mismatches;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_requests;

  // Walk or update the trie for one item and return its result.
  function automatic match_t trie_step(bit m, logic [23:0] a, logic [4:0] l,
                                       mtpm_pkg::id_t pid);
    match_t r;
    int i1, i2, i3, span, from, n2, e2, n3, k, ln;
    bit need2, need3;
    r = '0;
    i1 = a[23:16];
    i2 = a[15:8];
    i3 = a[7:0];
    ln = l;
    if (m) begin
      if (t1_valid[i1]) begin
        r.id = t1_id[i1];
        r.len = t1_len[i1];
      end
      if (t1_hc[i1]) begin
        e2 = t1_child[i1] * mtpm_pkg::FANOUT + i2;
        if (t2_valid[e2]) begin
          r.id = t2_id[e2];
          r.len = t2_len[e2];
        end
        if (t2_hc[e2]) begin
          n3 = t2_child[e2] * mtpm_pkg::FANOUT + i3;
          if (t3_valid[n3]) begin
            r.id = t3_id[n3];
            r.len = t3_len[n3];
          end
        end
      end
    end else if (ln <= 8) begin
      span = 1 << (8 - ln);
      from = i1 & ~(span - 1) & 255;
      for (k = from; k < from + span; k++) begin
        if (!t1_valid[k] || ln > t1_len[k]) begin
          t1_valid[k] = 1'b1;
          t1_id[k] = pid;
          t1_len[k] = l;
        end
      end
    end else if (ln <= mtpm_pkg::MAX_LEN) begin
      need2 = !t1_hc[i1];
      need3 = 1'b0;
      if (need2 && l2_taken >= mtpm_pkg::L2_NODES) begin
        r.status = mtpm_pkg::STATUS_L2_FULL;
      end else if (ln > 16) begin
        need3 = need2 || !t2_hc[t1_child[i1] * mtpm_pkg::FANOUT + i2];
        if (need3 && l3_taken >= mtpm_pkg::L3_NODES) r.status = mtpm_pkg::STATUS_L3_FULL;
      end
      if (r.status == mtpm_pkg::STATUS_OK) begin
        if (need2) begin
          for (k = 0; k < mtpm_pkg::FANOUT; k++) begin
            t2_valid[l2_taken * mtpm_pkg::FANOUT + k] = 1'b0;
            t2_hc[l2_taken * mtpm_pkg::FANOUT + k] = 1'b0;
          end
          t1_hc[i1] = 1'b1;
          t1_child[i1] = l2_taken;
          l2_taken++;
        end
        n2 = t1_child[i1] * mtpm_pkg::FANOUT;
        if (ln <= 16) begin
          span = 1 << (16 - ln);
          from = i2 & ~(span - 1) & 255;
          for (k = from; k < from + span; k++) begin
            if (!t2_valid[n2 + k] || ln > t2_len[n2 + k]) begin
              t2_valid[n2 + k] = 1'b1;
              t2_id[n2 + k] = pid;
              t2_len[n2 + k] = l;
            end
          end
        end else begin
          e2 = n2 + i2;
          if (need3) begin
            for (k = 0; k < mtpm_pkg::FANOUT; k++)
              t3_valid[l3_taken * mtpm_pkg::FANOUT + k] = 1'b0;
            t2_hc[e2] = 1'b1;
            t2_child[e2] = l3_taken;
            l3_taken++;
          end
          n3 = t2_child[e2] * mtpm_pkg::FANOUT;
          span = 1 << (24 - ln);
          from = i3 & ~(span - 1) & 255;
          for (k = from; k < from + span; k++) begin
            if (!t3_valid[n3 + k] || ln > t3_len[n3 + k]) begin
              t3_valid[n3 + k] = 1'b1;
              t3_id[n3 + k] = pid;
              t3_len[n3 + k] = l;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its result.
  task automatic send_item(bit m, logic [23:0] a, logic [4:0] l, logic [15:0] pid,
                           bit typed, match_t want);
    match_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    prefix_length <= l;
    prefix_id <= pid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = trie_step(m, a, l, pid);
    pending_matches.push_back(typed ? want : r);
    if (!m && l <= mtpm_pkg::MAX_LEN && known_prefixes.size() < 64)
      known_prefixes.push_back(a);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  // Mostly inserts and lookups along stored prefixes, with some noise.
  task automatic random_items(int count);
    int n, pick;
    logic [23:0] a;
    logic [4:0] l;
    bit m;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      a = 24'($urandom);
      if (known_prefixes.size() != 0 && $urandom_range(99) < 70) begin
        a = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
        a[7:0] = 8'($urandom);
        if ($urandom_range(1)) a[15:8] = 8'($urandom);
      end
      m = pick >= 30;
      if (pick < 5) l = 5'(25 + $urandom_range(6));
      else if (pick < 10) l = 5'($urandom_range(16));
      else l = 5'(17 + $urandom_range(7));
      send_item(m, a, l, 16'($urandom), 1'b0, '0);
    end
  endtask

  // Receiver: checks each transfer and draws the next ready.
  always @(posedge clk) begin : result_checker
    match_t want;
    int hold_left;
    int holds_seen;
    if (out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result id %h len %0d status %0d",
                                       best_id, best_length, status);
      end else begin
        want = pending_matches.pop_front();
        if (best_id !== want.id || best_length !== want.len || status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id %h len %0d status %0d, got id %h len %0d status %0d",
                     want.id, want.len, want.status, best_id, best_length, status);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  row_t rows [$];

  initial begin : stimulus
    int r, k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    hold_requests = 0;
    l2_taken = 0;
    l3_taken = 0;
    for (k = 0; k < mtpm_pkg::FANOUT; k++) begin
      t1_valid[k] = 1'b0;
      t1_hc[k] = 1'b0;
    end
    // Directed items after reset: lookups, ignored and plain inserts, some with typed results.
    rows = '{
      '{1'b1, 24'h000000, 5'd0,  16'h0000, 1'b1, '0},
      '{1'b1, 24'hFFFFFF, 5'd31, 16'hFFFF, 1'b1, '0},
      '{1'b0, 24'h123456, 5'd25, 16'h0001, 1'b1, '0},
      '{1'b0, 24'hFFFFFF, 5'd31, 16'hFFFF, 1'b1, '0},
      '{1'b1, 24'h123456, 5'd0,  16'h0000, 1'b1, '0},
      '{1'b0, 24'hFFFFFF, 5'd0,  16'h0001, 1'b1, '0},
      '{1'b1, 24'h123456, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b0, 24'hAB0000, 5'd8,  16'h0002, 1'b1, '0},
      '{1'b0, 24'hABFFFF, 5'd8,  16'h0003, 1'b1, '0},
      '{1'b1, 24'hAB1234, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b0, 24'hAB12FF, 5'd16, 16'hFFFF, 1'b1, '0},
      '{1'b0, 24'hAB1234, 5'd24, 16'h0000, 1'b1, '0},
      '{1'b1, 24'hAB1234, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b1, 24'hAB12FF, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b0, 24'h00FF00, 5'd9,  16'h0005, 1'b1, '0},
      '{1'b1, 24'h00AAAA, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b0, 24'hFFFFFF, 5'd17, 16'h0006, 1'b1, '0},
      '{1'b0, 24'hFFFFFE, 5'd23, 16'h0007, 1'b1, '0},
      '{1'b1, 24'hFFFFFF, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b1, 24'hFFFFFE, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b1, 24'hFFFF00, 5'd0,  16'h0000, 1'b0, '0},
      '{1'b0, 24'hF0FFFF, 5'd4,  16'h0008, 1'b1, '0},
      '{1'b1, 24'hF81234, 5'd0,  16'h0000, 1'b0, '0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (r = 0; r < rows.size(); r++)
      send_item(rows[r].mode, rows[r].address, rows[r].len, rows[r].id,
                rows[r].typed, rows[r].want);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items.
    hold_requests++;
    random_items(240);
    wait_drained();
    send_idle_pct = 52;
    random_items(240);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 52;
    random_items(240);
    wait_drained();
    send_idle_pct = 36;
    recv_stall_pct = 36;
    random_items(240);
    wait_drained();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("multibit_trie_prefix_match_core_test passed");
    end else begin
      $display("multibit_trie_prefix_match_core_test failed");
    end
    $finish;
  end

  // Run limit well beyond the slowest correct run.
  initial begin : run_limit
    #40000000;
    $display("multibit_trie_prefix_match_core_test failed");
    $finish;
  end

endmodule
